// ----- src/dfr_pkg.sv -----
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared types and constants of the sync-framed parameter deframer.
// ----------------------------------------------------------------------------
package dfr_pkg;

    // widths fixed by the channel payload
    localparam int MODE_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int OUTCOME_W = 2;
    localparam int PCNT_W    = 4;

    // default depth of the parameter chain
    localparam int MAX_PARAMS = 10;

    // framing constants
    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hFF;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hFE;
    localparam logic [WORD_W-1:0] PARAM_END   = 16'hFFFF;
    localparam logic [WORD_W-1:0] IDLE_MAX    = 16'hFFFF;

    // reset value of the idle limit register
    localparam logic [WORD_W-1:0] IDLE_LIMIT_RST = 16'd1000;

    // input beat kinds
    localparam logic [MODE_W-1:0] MODE_BYTE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_START = 2'd2;

    // result outcome codes
    localparam logic [OUTCOME_W-1:0] OC_OK         = 2'd0;
    localparam logic [OUTCOME_W-1:0] OC_NO_SYNC    = 2'd1;
    localparam logic [OUTCOME_W-1:0] OC_FRAME_TO   = 2'd2;
    localparam logic [OUTCOME_W-1:0] OC_OVERFLOW   = 2'd3;

    // shift command from the sequencer to the cell chain
    typedef struct packed {
        logic              en;
        logic [WORD_W-1:0] data;
    } t_shift;

endpackage

// ----- src/dfr_ifs.sv -----
// ----------------------------------------------------------------------------
// dfr_ifs
// Valid/ready channels of the deframer: input beats, results, configuration.
// ----------------------------------------------------------------------------
interface dfr_in_if;
    logic                           valid;
    logic                           ready;
    logic [dfr_pkg::MODE_W-1:0]     mode;
    logic [dfr_pkg::BYTE_W-1:0]     rx_byte;

    modport source (output valid, mode, rx_byte, input ready);
    modport sink   (input valid, mode, rx_byte, output ready);
endinterface

interface dfr_out_if;
    logic                           valid;
    logic                           ready;
    logic [dfr_pkg::OUTCOME_W-1:0]  outcome;
    logic [dfr_pkg::BYTE_W-1:0]     status_byte;
    logic [dfr_pkg::BYTE_W-1:0]     command_byte;
    logic [dfr_pkg::BYTE_W-1:0]     check_byte;
    logic                           has_param;
    logic [dfr_pkg::PCNT_W-1:0]     param_index;
    logic [dfr_pkg::WORD_W-1:0]     param_value;
    logic [dfr_pkg::PCNT_W-1:0]     param_count;
    logic                           last;

    modport source (output valid, outcome, status_byte, command_byte, check_byte,
                    has_param, param_index, param_value, param_count, last,
                    input ready);
    modport sink   (input valid, outcome, status_byte, command_byte, check_byte,
                    has_param, param_index, param_value, param_count, last,
                    output ready);
endinterface

interface dfr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dfr_pkg::WORD_W-1:0]     data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- src/dfr_cell.sv -----
// ----------------------------------------------------------------------------
// dfr_cell
// One stage of the parameter chain: holds a word, takes its neighbor's on shift.
// ----------------------------------------------------------------------------
module dfr_cell (
    input  logic                        i_clk,
    input  logic                        i_shift,
    input  logic [dfr_pkg::WORD_W-1:0]  i_d,
    output logic [dfr_pkg::WORD_W-1:0]  o_q
);

    logic [dfr_pkg::WORD_W-1:0] r_q;

    // word register, loads from the lower neighbor
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// ----- src/dfr_seq.sv -----
// ----------------------------------------------------------------------------
// dfr_seq
// Frame parser and result sequencer: sync hunt, header capture, parameter
// pairing, idle timeout, overflow check and the result run out of the chain.
// ----------------------------------------------------------------------------
module dfr_seq #(
    parameter int MAX_PARAMS = dfr_pkg::MAX_PARAMS,
    parameter int CNT_W      = $clog2(MAX_PARAMS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dfr_in_if.sink                      i_in,
    dfr_out_if.source                   o_out,
    dfr_cfg_if.sink                     i_cfg,
    input  logic [dfr_pkg::WORD_W-1:0]  i_tail,
    output dfr_pkg::t_shift             o_shift
);

    typedef enum logic [1:0] {
        S_RUN,
        S_ALIGN,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        PH_STATUS,
        PH_COMMAND,
        PH_CHECK,
        PH_HIGH,
        PH_LOW
    } t_phase;

    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_PARAMS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_PARAMS - 1);

    // control state
    t_state                         r_state,   n_state;
    logic                           r_armed,   n_armed;
    logic                           r_synced,  n_synced;
    logic                           r_saw_ff,  n_saw_ff;
    t_phase                         r_phase,   n_phase;
    logic [CNT_W-1:0]               r_count,   n_count;
    logic [CNT_W-1:0]               r_walk,    n_walk;
    logic [dfr_pkg::WORD_W-1:0]     r_idle,    n_idle;
    logic [dfr_pkg::WORD_W-1:0]     r_limit,   n_limit;
    logic                           r_ovalid,  n_ovalid;

    // frame payload
    logic [dfr_pkg::BYTE_W-1:0]     r_hdr_status,  n_hdr_status;
    logic [dfr_pkg::BYTE_W-1:0]     r_hdr_command, n_hdr_command;
    logic [dfr_pkg::BYTE_W-1:0]     r_hdr_check,   n_hdr_check;
    logic [dfr_pkg::BYTE_W-1:0]     r_high,        n_high;

    // result register
    logic [dfr_pkg::OUTCOME_W-1:0]  r_o_outcome,   n_o_outcome;
    logic [dfr_pkg::BYTE_W-1:0]     r_o_status,    n_o_status;
    logic [dfr_pkg::BYTE_W-1:0]     r_o_command,   n_o_command;
    logic [dfr_pkg::BYTE_W-1:0]     r_o_check,     n_o_check;
    logic                           r_o_has,       n_o_has;
    logic [dfr_pkg::PCNT_W-1:0]     r_o_index,     n_o_index;
    logic [dfr_pkg::WORD_W-1:0]     r_o_value,     n_o_value;
    logic [dfr_pkg::PCNT_W-1:0]     r_o_count,     n_o_count;
    logic                           r_o_last,      n_o_last;

    logic                           out_free;
    logic                           in_ready;
    logic                           in_fire;
    logic [dfr_pkg::WORD_W-1:0]     idle_inc;
    logic [dfr_pkg::WORD_W-1:0]     pair;
    dfr_pkg::t_shift                shift;

    // handshake
    assign out_free    = !r_ovalid || o_out.ready;
    assign in_ready    = (r_state == S_RUN) && out_free;
    assign in_fire     = i_in.valid && in_ready;
    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    // saturating idle count and assembled parameter word
    assign idle_inc = (r_idle == dfr_pkg::IDLE_MAX) ? r_idle : r_idle + 16'd1;
    assign pair     = {r_high, i_in.rx_byte};

    // next-state logic
    always_comb begin
        n_state       = r_state;
        n_armed       = r_armed;
        n_synced      = r_synced;
        n_saw_ff      = r_saw_ff;
        n_phase       = r_phase;
        n_count       = r_count;
        n_walk        = r_walk;
        n_idle        = r_idle;
        n_limit       = r_limit;
        n_ovalid      = r_ovalid;
        n_hdr_status  = r_hdr_status;
        n_hdr_command = r_hdr_command;
        n_hdr_check   = r_hdr_check;
        n_high        = r_high;
        n_o_outcome   = r_o_outcome;
        n_o_status    = r_o_status;
        n_o_command   = r_o_command;
        n_o_check     = r_o_check;
        n_o_has       = r_o_has;
        n_o_index     = r_o_index;
        n_o_value     = r_o_value;
        n_o_count     = r_o_count;
        n_o_last      = r_o_last;
        shift.en      = 1'b0;
        shift.data    = '0;

        if (i_cfg.valid) begin
            n_limit = i_cfg.data;
        end

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_RUN: begin
                if (in_fire) begin
                    case (i_in.mode)
                        dfr_pkg::MODE_START: begin
                            n_armed  = 1'b1;
                            n_synced = 1'b0;
                            n_saw_ff = 1'b0;
                            n_phase  = PH_STATUS;
                            n_count  = '0;
                            n_idle   = '0;
                        end
                        dfr_pkg::MODE_TICK: begin
                            if (r_armed) begin
                                n_idle = idle_inc;
                                // idle timeout, error beat and disarm
                                if (idle_inc >= r_limit) begin
                                    n_ovalid    = 1'b1;
                                    n_o_outcome = r_synced ? dfr_pkg::OC_FRAME_TO
                                                           : dfr_pkg::OC_NO_SYNC;
                                    n_o_status  = '0;
                                    n_o_command = '0;
                                    n_o_check   = '0;
                                    n_o_has     = 1'b0;
                                    n_o_index   = '0;
                                    n_o_value   = '0;
                                    n_o_count   = '0;
                                    n_o_last    = 1'b1;
                                    n_armed     = 1'b0;
                                    n_synced    = 1'b0;
                                    n_saw_ff    = 1'b0;
                                    n_phase     = PH_STATUS;
                                    n_count     = '0;
                                    n_idle      = '0;
                                end
                            end
                        end
                        dfr_pkg::MODE_BYTE: begin
                            if (r_armed) begin
                                n_idle = '0;
                                if (!r_synced) begin
                                    // sync hunt
                                    if (i_in.rx_byte == dfr_pkg::SYNC_FIRST) begin
                                        n_saw_ff = 1'b1;
                                    end else if (r_saw_ff &&
                                                 i_in.rx_byte == dfr_pkg::SYNC_SECOND) begin
                                        n_synced = 1'b1;
                                        n_phase  = PH_STATUS;
                                    end else begin
                                        n_saw_ff = 1'b0;
                                    end
                                end else begin
                                    case (r_phase)
                                        PH_STATUS: begin
                                            n_hdr_status = i_in.rx_byte;
                                            n_phase      = PH_COMMAND;
                                        end
                                        PH_COMMAND: begin
                                            n_hdr_command = i_in.rx_byte;
                                            n_phase       = PH_CHECK;
                                        end
                                        PH_CHECK: begin
                                            n_hdr_check = i_in.rx_byte;
                                            n_phase     = PH_HIGH;
                                        end
                                        PH_HIGH: begin
                                            n_high  = i_in.rx_byte;
                                            n_phase = PH_LOW;
                                        end
                                        PH_LOW: begin
                                            n_phase = PH_HIGH;
                                            if (pair != dfr_pkg::PARAM_END) begin
                                                if (r_count >= CNT_MAX) begin
                                                    // overflow error beat
                                                    n_ovalid    = 1'b1;
                                                    n_o_outcome = dfr_pkg::OC_OVERFLOW;
                                                    n_o_status  = '0;
                                                    n_o_command = '0;
                                                    n_o_check   = '0;
                                                    n_o_has     = 1'b0;
                                                    n_o_index   = '0;
                                                    n_o_value   = '0;
                                                    n_o_count   = '0;
                                                    n_o_last    = 1'b1;
                                                    n_armed     = 1'b0;
                                                    n_synced    = 1'b0;
                                                    n_saw_ff    = 1'b0;
                                                    n_phase     = PH_STATUS;
                                                    n_count     = '0;
                                                end else begin
                                                    // push the word into the chain
                                                    shift.en   = 1'b1;
                                                    shift.data = pair;
                                                    n_count    = r_count + 1'b1;
                                                end
                                            end else if (r_count == '0) begin
                                                // empty frame, one beat
                                                n_ovalid    = 1'b1;
                                                n_o_outcome = dfr_pkg::OC_OK;
                                                n_o_status  = r_hdr_status;
                                                n_o_command = r_hdr_command;
                                                n_o_check   = r_hdr_check;
                                                n_o_has     = 1'b0;
                                                n_o_index   = '0;
                                                n_o_value   = '0;
                                                n_o_count   = '0;
                                                n_o_last    = 1'b1;
                                                n_armed     = 1'b0;
                                                n_synced    = 1'b0;
                                                n_saw_ff    = 1'b0;
                                                n_phase     = PH_STATUS;
                                            end else begin
                                                // frame end, walk oldest word to the tail
                                                n_walk  = (r_count == CNT_MAX) ? '0 : r_count;
                                                n_state = (r_count == CNT_MAX) ? S_EMIT
                                                                               : S_ALIGN;
                                            end
                                        end
                                        default: begin
                                            n_phase = PH_STATUS;
                                        end
                                    endcase
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_ALIGN: begin
                shift.en = 1'b1;
                n_walk   = r_walk + 1'b1;
                if (r_walk == CNT_LAST) begin
                    n_walk  = '0;
                    n_state = S_EMIT;
                end
            end

            S_EMIT: begin
                // r_walk counts emitted parameters here
                if (out_free) begin
                    shift.en    = 1'b1;
                    n_ovalid    = 1'b1;
                    n_o_outcome = dfr_pkg::OC_OK;
                    n_o_status  = r_hdr_status;
                    n_o_command = r_hdr_command;
                    n_o_check   = r_hdr_check;
                    n_o_has     = 1'b1;
                    n_o_index   = dfr_pkg::PCNT_W'(r_walk);
                    n_o_value   = i_tail;
                    n_o_count   = dfr_pkg::PCNT_W'(r_count);
                    n_o_last    = (r_walk + 1'b1 == r_count);
                    n_walk      = r_walk + 1'b1;
                    if (r_walk + 1'b1 == r_count) begin
                        n_state  = S_RUN;
                        n_walk   = '0;
                        n_armed  = 1'b0;
                        n_synced = 1'b0;
                        n_saw_ff = 1'b0;
                        n_phase  = PH_STATUS;
                        n_count  = '0;
                        n_idle   = '0;
                    end
                end
            end

            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_RUN;
            r_armed  <= 1'b0;
            r_synced <= 1'b0;
            r_saw_ff <= 1'b0;
            r_phase  <= PH_STATUS;
            r_count  <= '0;
            r_walk   <= '0;
            r_idle   <= '0;
            r_limit  <= dfr_pkg::IDLE_LIMIT_RST;
            r_ovalid <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_armed       <= n_armed;
            r_synced      <= n_synced;
            r_saw_ff      <= n_saw_ff;
            r_phase       <= n_phase;
            r_count       <= n_count;
            r_walk        <= n_walk;
            r_idle        <= n_idle;
            r_limit       <= n_limit;
            r_ovalid      <= n_ovalid;
            r_hdr_status  <= n_hdr_status;
            r_hdr_command <= n_hdr_command;
            r_hdr_check   <= n_hdr_check;
            r_high        <= n_high;
            r_o_outcome   <= n_o_outcome;
            r_o_status    <= n_o_status;
            r_o_command   <= n_o_command;
            r_o_check     <= n_o_check;
            r_o_has       <= n_o_has;
            r_o_index     <= n_o_index;
            r_o_value     <= n_o_value;
            r_o_count     <= n_o_count;
            r_o_last      <= n_o_last;
        end
    end

    // result channel
    assign o_out.valid        = r_ovalid;
    assign o_out.outcome      = r_o_outcome;
    assign o_out.status_byte  = r_o_status;
    assign o_out.command_byte = r_o_command;
    assign o_out.check_byte   = r_o_check;
    assign o_out.has_param    = r_o_has;
    assign o_out.param_index  = r_o_index;
    assign o_out.param_value  = r_o_value;
    assign o_out.param_count  = r_o_count;
    assign o_out.last         = r_o_last;

    assign o_shift = shift;

endmodule

// ----- src/sync_framed_param_deframer.sv -----
// ----------------------------------------------------------------------------
// sync_framed_param_deframer
// Hunts for the 0xFF 0xFE sync pair, captures a three-byte header and 16-bit
// parameters to the 0xFFFF terminator; emits one result per parameter, one if none.
//
//   channel   dir  handshake             payload
//   i_in      in   valid / ready         mode, rx_byte
//   o_out     out  valid / ready         outcome, header bytes, param fields, last
//   i_cfg     in   valid / ready (=1)    data -> idle_limit
//
// A result beat leaves through an output register, and no input beat is taken
// while that register holds a beat that o_out does not take in the same cycle.
// At frame end the cell chain first shifts until the oldest word reaches the
// tail, then emits one beat per cycle as o_out allows; no input beat is taken
// during that run. MAX_PARAMS range is 1 to 15.
// Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module sync_framed_param_deframer #(
    parameter int MAX_PARAMS = dfr_pkg::MAX_PARAMS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dfr_in_if.sink      i_in,
    dfr_out_if.source   o_out,
    dfr_cfg_if.sink     i_cfg
);

    localparam int CNT_W = $clog2(MAX_PARAMS + 1);

    dfr_pkg::t_shift            shift;
    logic [dfr_pkg::WORD_W-1:0] cell_q [MAX_PARAMS];

    // parser and sequencer
    dfr_seq #(
        .MAX_PARAMS (MAX_PARAMS),
        .CNT_W      (CNT_W)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .i_tail  (cell_q[MAX_PARAMS-1]),
        .o_shift (shift)
    );

    // parameter chain, new words enter at cell 0 and move toward the tail
    for (genvar g = 0; g < MAX_PARAMS; g++) begin : g_cell
        if (g == 0) begin : g_head
            dfr_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (shift.en),
                .i_d     (shift.data),
                .o_q     (cell_q[g])
            );
        end else begin : g_body
            dfr_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (shift.en),
                .i_d     (cell_q[g-1]),
                .o_q     (cell_q[g])
            );
        end
    end

endmodule

// ----- src/dfr_chk.sv -----
// ----------------------------------------------------------------------------
// dfr_chk
// Port-level checker for the deframer result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dfr_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            i_ready,
    input  logic [dfr_pkg::OUTCOME_W-1:0]   i_outcome,
    input  logic                            i_has_param,
    input  logic [dfr_pkg::PCNT_W-1:0]      i_param_index,
    input  logic [dfr_pkg::WORD_W-1:0]      i_param_value,
    input  logic [dfr_pkg::PCNT_W-1:0]      i_param_count,
    input  logic                            i_last
);

    // error beats are lone, empty and closing
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_outcome != dfr_pkg::OC_OK
        |-> i_last && !i_has_param && i_param_count == '0)
        else $error("error beat carries frame data");

    // frame without parameters is one closing beat
    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_has_param |-> i_last && i_param_count == '0)
        else $error("empty frame beat malformed");

    // parameter index within count, last on the final one
    a_param_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_has_param
        |-> i_param_index < i_param_count
            && (i_last == (i_param_index + 4'd1 == i_param_count)))
        else $error("parameter index or last flag wrong");

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready
        |=> i_valid && $stable(i_param_value) && $stable(i_param_index)
            && $stable(i_outcome))
        else $error("stalled result beat changed");

endmodule

bind sync_framed_param_deframer dfr_chk u_dfr_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_out.valid),
    .i_ready       (o_out.ready),
    .i_outcome     (o_out.outcome),
    .i_has_param   (o_out.has_param),
    .i_param_index (o_out.param_index),
    .i_param_value (o_out.param_value),
    .i_param_count (o_out.param_count),
    .i_last        (o_out.last)
);

// ----- tb/sync_framed_param_deframer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_framed_param_deframer_test
// Self-checking bench for the deframer. A driver and a monitor run on the
// clock; an in-bench predictor turns every accepted input beat into the
// results it should produce, and the monitor compares each result beat field
// by field. Directed frames cover timeouts, sync corner cases, overflow and
// start while armed. Random frames then run under several idle/stall mixes.
// ----------------------------------------------------------------------------
module sync_framed_param_deframer_test;

    localparam int MODE_W     = dfr_pkg::MODE_W;
    localparam int BYTE_W     = dfr_pkg::BYTE_W;
    localparam int WORD_W     = dfr_pkg::WORD_W;
    localparam int OUTCOME_W  = dfr_pkg::OUTCOME_W;
    localparam int PCNT_W     = dfr_pkg::PCNT_W;
    localparam int MAX_PARAMS = dfr_pkg::MAX_PARAMS;

    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_BEATS  = 16;
    localparam int LONG_HOLD    = 400;

    // spare beat kind, ignored by the block
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef enum logic [2:0] {
        POS_STATUS, POS_COMMAND, POS_CHECK, POS_HIGH, POS_LOW
    } t_field_pos;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [BYTE_W-1:0] data;
    } t_beat;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [BYTE_W-1:0]    status_byte;
        logic [BYTE_W-1:0]    command_byte;
        logic [BYTE_W-1:0]    check_byte;
        logic                 has_param;
        logic [PCNT_W-1:0]    param_index;
        logic [WORD_W-1:0]    param_value;
        logic [PCNT_W-1:0]    param_count;
        logic                 last;
    } t_frame_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dfr_in_if  in_if ();
    dfr_out_if out_if ();
    dfr_cfg_if cfg_if ();

    sync_framed_param_deframer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // pending input beats and results still owed by the block
    t_beat         tx_beats[$];
    t_frame_result frame_results_due[$];
    t_beat         cur_beat;
    logic          drv_busy;

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int beats_queued  = 0;
    int results_seen  = 0;
    int mismatch_count = 0;

    // long receiver hold-off, requested from the stimulus process
    int hold_len    = 0;
    int hold_seq    = 0;
    int hold_seen   = 0;
    int hold_cycles = 0;

    // predictor state
    logic [WORD_W-1:0] tick_limit;
    logic              rx_armed;
    logic              in_frame;
    logic              ff_seen;
    t_field_pos        field_pos;
    logic [BYTE_W-1:0] hdr_st, hdr_cmd, hdr_chk;
    logic [BYTE_W-1:0] word_hi;
    logic [WORD_W-1:0] word_buf[MAX_PARAMS];
    int                word_cnt;
    logic [WORD_W-1:0] tick_run;

    logic [WORD_W-1:0] corner_words[6] = '{16'h0000, 16'hFFFE, 16'hFF00,
                                           16'h00FF, 16'h8000, 16'h7FFF};

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void clear_frame_state();
        in_frame  = 1'b0;
        ff_seen   = 1'b0;
        field_pos = POS_STATUS;
        hdr_st    = '0;
        hdr_cmd   = '0;
        hdr_chk   = '0;
        word_hi   = '0;
        word_cnt  = 0;
        tick_run  = '0;
    endfunction

    function automatic void push_error(input logic [OUTCOME_W-1:0] code);
        t_frame_result r;
        r         = '0;
        r.outcome = code;
        r.last    = 1'b1;
        frame_results_due.push_back(r);
        rx_armed = 1'b0;
        clear_frame_state();
    endfunction

    function automatic void deframe_beat(input t_beat b);
        t_frame_result     r;
        logic [WORD_W-1:0] word;
        case (b.mode)
            dfr_pkg::MODE_START: begin
                rx_armed = 1'b1;
                clear_frame_state();
            end
            dfr_pkg::MODE_TICK: begin
                if (rx_armed) begin
                    if (tick_run != dfr_pkg::IDLE_MAX) tick_run = tick_run + 1'b1;
                    if (tick_run >= tick_limit)
                        push_error(in_frame ? dfr_pkg::OC_FRAME_TO : dfr_pkg::OC_NO_SYNC);
                end
            end
            dfr_pkg::MODE_BYTE: begin
                if (!rx_armed) return;
                tick_run = '0;
                // hunting for the sync pair
                if (!in_frame) begin
                    if (b.data == dfr_pkg::SYNC_FIRST) begin
                        ff_seen = 1'b1;
                    end else if (ff_seen && b.data == dfr_pkg::SYNC_SECOND) begin
                        in_frame  = 1'b1;
                        field_pos = POS_STATUS;
                    end else begin
                        ff_seen = 1'b0;
                    end
                    return;
                end
                case (field_pos)
                    POS_STATUS:  begin hdr_st  = b.data; field_pos = POS_COMMAND; return; end
                    POS_COMMAND: begin hdr_cmd = b.data; field_pos = POS_CHECK;   return; end
                    POS_CHECK:   begin hdr_chk = b.data; field_pos = POS_HIGH;    return; end
                    POS_HIGH:    begin word_hi = b.data; field_pos = POS_LOW;     return; end
                    default: ;
                endcase
                // low byte completes a word
                word      = {word_hi, b.data};
                field_pos = POS_HIGH;
                if (word != dfr_pkg::PARAM_END) begin
                    if (word_cnt >= MAX_PARAMS) begin
                        push_error(dfr_pkg::OC_OVERFLOW);
                    end else begin
                        word_buf[word_cnt] = word;
                        word_cnt++;
                    end
                    return;
                end
                // terminator: emit the frame
                r              = '0;
                r.outcome      = dfr_pkg::OC_OK;
                r.status_byte  = hdr_st;
                r.command_byte = hdr_cmd;
                r.check_byte   = hdr_chk;
                if (word_cnt == 0) begin
                    r.last = 1'b1;
                    frame_results_due.push_back(r);
                end else begin
                    for (int i = 0; i < word_cnt; i++) begin
                        r.has_param   = 1'b1;
                        r.param_index = PCNT_W'(i);
                        r.param_value = word_buf[i];
                        r.param_count = PCNT_W'(word_cnt);
                        r.last        = (i == word_cnt - 1);
                        frame_results_due.push_back(r);
                    end
                end
                rx_armed = 1'b0;
                clear_frame_state();
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d: %s got 0x%0h want 0x%0h",
                                      results_seen, name, got, want));
    endtask

    task automatic check_result();
        t_frame_result want;
        if (frame_results_due.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
        end else begin
            want = frame_results_due.pop_front();
            compare_field("outcome",      WORD_W'(out_if.outcome),
                          WORD_W'(want.outcome));
            compare_field("status_byte",  WORD_W'(out_if.status_byte),
                          WORD_W'(want.status_byte));
            compare_field("command_byte", WORD_W'(out_if.command_byte),
                          WORD_W'(want.command_byte));
            compare_field("check_byte",   WORD_W'(out_if.check_byte),
                          WORD_W'(want.check_byte));
            compare_field("has_param",    WORD_W'(out_if.has_param),
                          WORD_W'(want.has_param));
            compare_field("param_index",  WORD_W'(out_if.param_index),
                          WORD_W'(want.param_index));
            compare_field("param_value",  out_if.param_value, want.param_value);
            compare_field("param_count",  WORD_W'(out_if.param_count),
                          WORD_W'(want.param_count));
            compare_field("last",         WORD_W'(out_if.last),
                          WORD_W'(want.last));
        end
        results_seen++;
    endtask

    // ------------------------------------------------------------------
    // driver: one beat at a time from the pending queue
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            drv_busy = in_if.valid;
            if (in_if.valid && in_if.ready) begin
                deframe_beat(cur_beat);
                drv_busy = 1'b0;
            end
            if (!drv_busy) begin
                if (tx_beats.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    cur_beat = tx_beats.pop_front();
                    in_if.valid   <= 1'b1;
                    in_if.mode    <= cur_beat.mode;
                    in_if.rx_byte <= cur_beat.data;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver hold-off counter
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cycles <= 0;
            hold_seen   <= 0;
        end else if (hold_seq != hold_seen) begin
            hold_cycles <= hold_len;
            hold_seen   <= hold_seq;
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // monitor: check each result beat, randomize ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) check_result();
            out_if.ready <= (hold_cycles == 0) && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_beat(input logic [MODE_W-1:0] mode,
                                      input logic [BYTE_W-1:0] data);
        t_beat b;
        b.mode = mode;
        b.data = data;
        tx_beats.push_back(b);
        beats_queued++;
    endfunction

    function automatic void push_byte(input logic [BYTE_W-1:0] data);
        push_beat(dfr_pkg::MODE_BYTE, data);
    endfunction

    function automatic void push_word(input logic [WORD_W-1:0] w);
        push_byte(w[15:8]);
        push_byte(w[7:0]);
    endfunction

    function automatic void push_ticks(input int n);
        repeat (n) push_beat(dfr_pkg::MODE_TICK, BYTE_W'($urandom));
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return ($urandom_range(4) == 0) ? dfr_pkg::SYNC_FIRST : BYTE_W'($urandom);
    endfunction

    // short tick runs between bytes, now and then a full timeout
    function automatic void idle_gap();
        int cap;
        cap = (tick_limit > 1) ? int'(tick_limit) - 1 : 0;
        if ($urandom_range(99) < 10) push_ticks($urandom_range(0, cap));
        if ($urandom_range(299) == 0) push_ticks((tick_limit == 0) ? 1 : int'(tick_limit));
    endfunction

    function automatic void queue_random_frame(input bit max_words);
        int                r;
        int                n_words;
        logic [WORD_W-1:0] w;
        r = $urandom_range(99);
        // noise of every beat kind
        if (!max_words && r < 8) begin
            repeat ($urandom_range(1, 6))
                push_beat(MODE_W'($urandom_range(0, 3)), BYTE_W'($urandom));
            return;
        end
        push_beat(dfr_pkg::MODE_START, BYTE_W'($urandom));
        // read abandoned by a fresh start
        if (!max_words && r < 18) begin
            push_byte(dfr_pkg::SYNC_FIRST);
            push_byte(dfr_pkg::SYNC_SECOND);
            repeat ($urandom_range(0, 4)) push_byte(BYTE_W'($urandom));
            push_beat(dfr_pkg::MODE_START, BYTE_W'($urandom));
        end
        repeat ($urandom_range(0, 3)) begin
            push_byte(rand_byte());
            idle_gap();
        end
        push_byte(dfr_pkg::SYNC_FIRST);
        idle_gap();
        push_byte(dfr_pkg::SYNC_SECOND);
        idle_gap();
        repeat (3) begin
            push_byte(rand_byte());
            idle_gap();
        end
        r = $urandom_range(99);
        if (max_words || r < 12)  n_words = MAX_PARAMS;
        else if (r < 20)          n_words = MAX_PARAMS + 1;
        else                      n_words = $urandom_range(0, MAX_PARAMS - 1);
        repeat (n_words) begin
            if ($urandom_range(3) == 0) w = corner_words[$urandom_range(5)];
            else                        w = WORD_W'($urandom);
            if (w == dfr_pkg::PARAM_END) w = 16'hFFFE;
            push_byte(w[15:8]);
            idle_gap();
            push_byte(w[7:0]);
            idle_gap();
        end
        if (n_words <= MAX_PARAMS) begin
            push_byte(dfr_pkg::PARAM_END[15:8]);
            idle_gap();
            push_byte(dfr_pkg::PARAM_END[7:0]);
        end
    endfunction

    task automatic write_idle_limit(input logic [WORD_W-1:0] v);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        tick_limit = v;
        @(negedge i_clk);
    endtask

    // sender pauses until every owed result is in, then lets the block settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (tx_beats.size() != 0 || in_if.valid || frame_results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        int n0;
        in_if.valid   = 1'b0;
        in_if.mode    = dfr_pkg::MODE_BYTE;
        in_if.rx_byte = '0;
        out_if.ready  = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = '0;
        tick_limit    = dfr_pkg::IDLE_LIMIT_RST;
        rx_armed      = 1'b0;
        clear_frame_state();
        foreach (word_buf[i]) word_buf[i] = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // beats while not armed are dropped
        push_byte(dfr_pkg::SYNC_FIRST);
        push_beat(dfr_pkg::MODE_TICK, 8'h00);
        push_beat(MODE_SPARE, 8'hFF);
        // reset idle limit: short tick runs around a byte stay armed
        push_beat(dfr_pkg::MODE_START, 8'h00);
        push_ticks(5);
        push_byte(8'h00);
        push_ticks(3);
        // repeated 0xFF before sync, header bytes equal to the terminator
        push_beat(dfr_pkg::MODE_START, 8'h00);
        push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFE);
        push_byte(8'hFF); push_byte(8'hFF); push_byte(8'h00);
        push_beat(MODE_SPARE, 8'h12);
        push_word(16'h0000); push_word(16'hFFFE); push_word(16'hFF00); push_word(16'h00FF);
        push_word(dfr_pkg::PARAM_END);
        // junk before sync, frame with no parameters
        push_beat(dfr_pkg::MODE_START, 8'h00);
        push_byte(8'h12); push_byte(8'hFF); push_byte(8'h34);
        push_byte(8'hFF); push_byte(8'hFE);
        push_byte(8'hA5); push_byte(8'h5A); push_byte(8'hC3);
        push_word(dfr_pkg::PARAM_END);
        // start while armed drops the running read
        push_beat(dfr_pkg::MODE_START, 8'h00);
        push_byte(8'hFF); push_byte(8'hFE); push_byte(8'h01); push_byte(8'h02);
        push_beat(dfr_pkg::MODE_START, 8'hFF);
        push_byte(8'hFF); push_byte(8'hFE);
        push_byte(8'h11); push_byte(8'h22); push_byte(8'h33);
        push_word(16'h1234); push_word(dfr_pkg::PARAM_END);
        // one word past the store overflows
        push_beat(dfr_pkg::MODE_START, 8'h00);
        push_byte(8'hFF); push_byte(8'hFE);
        push_byte(8'h80); push_byte(8'h7F); push_byte(8'h55);
        for (int i = 0; i < MAX_PARAMS; i++) push_word(WORD_W'(16'h1111 * (i + 1)));
        push_word(16'hABCD);
        push_word(dfr_pkg::PARAM_END);
        wait_drained();

        // limit 1: first tick times out, hunting and in frame
        write_idle_limit(16'd1);
        push_beat(dfr_pkg::MODE_START, 8'h00);
        push_beat(dfr_pkg::MODE_TICK, 8'h00);
        push_beat(dfr_pkg::MODE_TICK, 8'h00);
        push_beat(dfr_pkg::MODE_START, 8'h00);
        push_byte(8'hFF); push_byte(8'hFE);
        push_beat(dfr_pkg::MODE_TICK, 8'h00);
        wait_drained();

        // zero limit acts like one
        write_idle_limit(16'd0);
        push_beat(dfr_pkg::MODE_START, 8'h00);
        push_byte(8'hFF);
        push_beat(dfr_pkg::MODE_TICK, 8'h00);
        push_beat(dfr_pkg::MODE_START, 8'h00);
        push_byte(8'hFF); push_byte(8'hFE); push_byte(8'h7E);
        push_beat(dfr_pkg::MODE_TICK, 8'h00);
        wait_drained();

        // limit 3: a byte restarts the count, a full run times out in frame
        write_idle_limit(16'd3);
        push_beat(dfr_pkg::MODE_START, 8'h00);
        push_ticks(2);
        push_byte(8'hFF); push_byte(8'hFE);
        push_ticks(2);
        push_byte(8'h44);
        push_ticks(3);
        wait_drained();

        // random frames under four idle/stall mixes
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 81; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 81; end
                default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
            endcase
            write_idle_limit(WORD_W'($urandom_range(1, 12)));
            if (p == 0) begin
                hold_len = LONG_HOLD;
                hold_seq++;
            end
            n0 = beats_queued;
            queue_random_frame(p == 0);
            while (beats_queued - n0 < PHASE_BEATS) queue_random_frame(1'b0);
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
src/dfr_pkg.sv
src/dfr_ifs.sv
src/dfr_cell.sv
src/dfr_seq.sv
src/sync_framed_param_deframer.sv
src/dfr_chk.sv
tb/sync_framed_param_deframer_test.sv
